// File: rtl/blm_pkg.sv
// ---------------------------------------------------------------------------
// blm_pkg: shared constants for the bus load meter
// widths of the serial arithmetic units and register indexes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package blm_pkg;

  localparam int DATA_W  = 32;
  localparam int MUL_W   = 17;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 8;

  localparam logic [MUL_W-1:0] RATE_SCALE = MUL_W'(1000);

  localparam logic [ADDR_W-1:0] REG_INTERVAL  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] REG_OCTET     = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] REG_FRAME_GAP = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] REG_ACK_SLOT  = ADDR_W'(3);

  localparam logic [CFG_W-1:0] INTERVAL_RST  = CFG_W'(1000);
  localparam logic [CFG_W-1:0] OCTET_RST     = CFG_W'(1354);
  localparam logic [CFG_W-1:0] FRAME_GAP_RST = CFG_W'(5200);
  localparam logic [CFG_W-1:0] ACK_SLOT_RST  = CFG_W'(2916);

endpackage

// File: rtl/bus_load_meter.sv
// ---------------------------------------------------------------------------
// bus_load_meter: bus load meter over running byte and frame totals
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tdata 64b, tuser 2b
//   out_     out  out_tvalid/out_tready  tdata 48b, tuser 1b
//   cfg_     in   cfg_we                 cfg_addr 8b, cfg_wdata 16b
//
// a word that does not evaluate passes the prep state on its way to the output
// register, a clear goes straight from idle; an evaluating sample also passes
// load, the three 17-bit serial multipliers and the two 32-bit serial dividers
// one word is worked on at a time; in_tready is high only when idle
// the output register holds a result while the next word is accepted
// synchronous active-low reset clears totals, reference, results and fsm
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_load_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_bytes_add[15:0], good_frames_add[23:16], bad_frames_add[31:24], now_ms[63:32]
  input  logic [63:0] in_tdata,
  // sample[0], clear[1]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bytes_per_second[31:0], load_percent[47:32]
  output logic [47:0] out_tdata,
  // updated[0]
  output logic [0:0]  out_tuser,
  input  logic                        cfg_we,
  input  logic [blm_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [blm_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int DW = blm_pkg::DATA_W;
  localparam int MW = blm_pkg::MUL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_LOAD, S_MUL, S_DIVST, S_DIV, S_DELIVER
  } state_t;

  state_t state_r;

  logic [15:0]   interval_r, octet_r, gap_r, ack_r;
  logic [DW-1:0] byte_total_r, frame_total_r;
  logic [DW-1:0] ref_bytes_r, ref_frames_r, ref_time_r;
  logic          ref_valid_r;
  logic [DW-1:0] rate_reg_r;
  logic [15:0]   pct_reg_r;
  logic          samp_r, upd_r;
  logic [DW-1:0] now_r, octets_r, frames_r, elapsed_r, div10_r;
  logic          out_valid_r;
  logic [47:0]   out_data_r;
  logic          out_user_r;

  logic [DW-1:0] elapsed;
  logic          mul_start, div_start;
  logic          busy_a, busy_b, busy_c, busy_q1, busy_q2;
  logic          mul_busy, div_busy;
  logic [DW-1:0] prod_a, prod_b, prod_c, quot_rate, quot_pct;
  logic [DW-1:0] rate_num, busy_sum;
  logic          accept, out_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign elapsed   = now_r - ref_time_r;
  assign mul_start = (state_r == S_LOAD);
  assign div_start = (state_r == S_DIVST);
  assign mul_busy  = busy_a || busy_b || busy_c;
  assign div_busy  = busy_q1 || busy_q2;
  // rounding term is half the elapsed time
  assign rate_num  = prod_c + {1'b0, elapsed_r[DW-1:1]};
  assign busy_sum  = prod_a + prod_b;

  blm_mul #(.DW(DW), .MW(MW)) u_mul_octet (
    .clk(clk), .rst_n(rst_n), .start_i(mul_start),
    .mcand_i(octets_r), .mplier_i(MW'(octet_r)),
    .busy_o(busy_a), .prod_o(prod_a)
  );

  blm_mul #(.DW(DW), .MW(MW)) u_mul_frame (
    .clk(clk), .rst_n(rst_n), .start_i(mul_start),
    .mcand_i(frames_r), .mplier_i(MW'(gap_r) + MW'(ack_r)),
    .busy_o(busy_b), .prod_o(prod_b)
  );

  blm_mul #(.DW(DW), .MW(MW)) u_mul_rate (
    .clk(clk), .rst_n(rst_n), .start_i(mul_start),
    .mcand_i(octets_r), .mplier_i(blm_pkg::RATE_SCALE),
    .busy_o(busy_c), .prod_o(prod_c)
  );

  blm_div #(.W(DW)) u_div_rate (
    .clk(clk), .rst_n(rst_n), .start_i(div_start),
    .dividend_i(rate_num), .divisor_i(elapsed_r),
    .busy_o(busy_q1), .quot_o(quot_rate)
  );

  blm_div #(.W(DW)) u_div_pct (
    .clk(clk), .rst_n(rst_n), .start_i(div_start),
    .dividend_i(busy_sum), .divisor_i(div10_r),
    .busy_o(busy_q2), .quot_o(quot_pct)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= blm_pkg::INTERVAL_RST;
      octet_r    <= blm_pkg::OCTET_RST;
      gap_r      <= blm_pkg::FRAME_GAP_RST;
      ack_r      <= blm_pkg::ACK_SLOT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        blm_pkg::REG_INTERVAL:  interval_r <= cfg_wdata;
        blm_pkg::REG_OCTET:     octet_r    <= cfg_wdata;
        blm_pkg::REG_FRAME_GAP: gap_r      <= cfg_wdata;
        blm_pkg::REG_ACK_SLOT:  ack_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      byte_total_r  <= '0;
      frame_total_r <= '0;
      ref_bytes_r   <= '0;
      ref_frames_r  <= '0;
      ref_time_r    <= '0;
      ref_valid_r   <= 1'b0;
      rate_reg_r    <= '0;
      pct_reg_r     <= '0;
      upd_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DELIVER) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            upd_r  <= 1'b0;
            samp_r <= in_tuser[0];
            now_r  <= in_tdata[63:32];
            if (in_tuser[1]) begin
              byte_total_r  <= '0;
              frame_total_r <= '0;
              ref_bytes_r   <= '0;
              ref_frames_r  <= '0;
              ref_time_r    <= '0;
              ref_valid_r   <= 1'b0;
              rate_reg_r    <= '0;
              pct_reg_r     <= '0;
              state_r       <= S_DELIVER;
            end else begin
              byte_total_r  <= byte_total_r + DW'(in_tdata[15:0]);
              frame_total_r <= frame_total_r + DW'(in_tdata[23:16])
                               + DW'(in_tdata[31:24]);
              state_r       <= S_PREP;
            end
          end
        end
        S_PREP: begin
          if (!samp_r) begin
            state_r <= S_DELIVER;
          end else if (!ref_valid_r) begin
            ref_bytes_r  <= byte_total_r;
            ref_frames_r <= frame_total_r;
            ref_time_r   <= now_r;
            ref_valid_r  <= 1'b1;
            state_r      <= S_DELIVER;
          end else if (elapsed < DW'(interval_r)) begin
            state_r <= S_DELIVER;
          end else begin
            octets_r     <= byte_total_r - ref_bytes_r;
            frames_r     <= frame_total_r - ref_frames_r;
            elapsed_r    <= elapsed;
            ref_bytes_r  <= byte_total_r;
            ref_frames_r <= frame_total_r;
            ref_time_r   <= now_r;
            state_r      <= S_LOAD;
          end
        end
        S_LOAD: begin
          // times ten as eight plus two
          div10_r <= {elapsed_r[DW-4:0], 3'b000} + {elapsed_r[DW-2:0], 1'b0};
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (!mul_busy) begin
            state_r <= S_DIVST;
          end
        end
        S_DIVST: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            rate_reg_r <= quot_rate;
            pct_reg_r  <= (quot_pct[DW-1:16] != '0) ? 16'hFFFF : quot_pct[15:0];
            upd_r      <= 1'b1;
            state_r    <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {pct_reg_r, rate_reg_r};
            out_user_r  <= upd_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

  a_mul_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_busy |-> state_r == S_MUL)
    else $error("multiplier busy outside multiply state");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DIV)
    else $error("divider busy outside divide state");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(div_busy) |-> $past(state_r) == S_DIVST)
    else $error("divider started without start state");

  a_no_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !ref_valid_r |-> (rate_reg_r == '0 && pct_reg_r == '0))
    else $error("results nonzero without reference point");

endmodule

// File: rtl/blm_mul.sv
// ---------------------------------------------------------------------------
// blm_mul: serial shift-add multiplier
// one multiplier bit per cycle, product kept modulo 2^DW
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module blm_mul #(
  parameter int DW = blm_pkg::DATA_W,
  parameter int MW = blm_pkg::MUL_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [DW-1:0] mcand_i,
  input  logic [MW-1:0] mplier_i,
  output logic          busy_o,
  output logic [DW-1:0] prod_o
);

  localparam int CW = $clog2(MW + 1);

  logic [CW-1:0] cnt_r;
  logic [DW-1:0] mcand_r;
  logic [MW-1:0] mplier_r;
  logic [DW-1:0] acc_r;
  logic [DW-1:0] acc_nxt;

  assign acc_nxt = acc_r + (mplier_r[0] ? mcand_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= CW'(MW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      mcand_r  <= mcand_i;
      mplier_r <= mplier_i;
      acc_r    <= '0;
    end else if (cnt_r != '0) begin
      mcand_r  <= {mcand_r[DW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[MW-1:1]};
      acc_r    <= acc_nxt;
    end
  end

  assign busy_o = (cnt_r != '0);
  assign prod_o = acc_r;

endmodule

// File: rtl/blm_div.sv
// ---------------------------------------------------------------------------
// blm_div: serial restoring divider
// one quotient bit per cycle; a zero divisor gives an all-ones quotient
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module blm_div #(
  parameter int W = blm_pkg::DATA_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quot_o
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_r;
  logic [W-1:0]  quot_r;
  logic [W-1:0]  dvsr_r;
  logic [W-1:0]  rem_r;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_diff;
  logic          take;

  assign rem_sh   = {rem_r, quot_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, dvsr_r};
  assign take     = (rem_sh >= {1'b0, dvsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= CW'(W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quot_r <= dividend_i;
      dvsr_r <= divisor_i;
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= take ? rem_diff[W-1:0] : rem_sh[W-1:0];
      quot_r <= {quot_r[W-2:0], take};
    end
  end

  assign busy_o = (cnt_r != '0);
  assign quot_o = quot_r;

endmodule

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for bus_load_meter
// a queue-fed driver offers words on the in_ stream, a predictor computes the
// expected rate, load and update flag of every accepted word, and a monitor
// compares each out_ word with the oldest prediction; directed corner cases
// come first, then random traffic under several register settings, with
// random idle bursts on both sides until the last setting and one long output hold-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT        = 400;

  typedef struct packed {
    logic [15:0] frame_bytes;
    logic [7:0]  good_frames;
    logic [7:0]  bad_frames;
    logic        strobe;
    logic [31:0] now_ms;
    logic        clear;
  } bus_word_t;

  typedef struct packed {
    logic [31:0] rate;
    logic [15:0] percent;
    logic        updated;
  } load_result_t;

  typedef struct packed {
    logic [31:0] byte_total;
    logic [31:0] frame_total;
    logic [31:0] ref_bytes;
    logic [31:0] ref_frames;
    logic [31:0] ref_time;
    logic        ref_valid;
    logic [31:0] rate;
    logic [15:0] percent;
  } meter_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic                       cfg_we = 1'b0;
  logic [blm_pkg::ADDR_W-1:0] cfg_addr = '0;
  logic [blm_pkg::CFG_W-1:0]  cfg_wdata = '0;

  bus_load_meter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bus_word_t    pending_words[$];
  load_result_t expected_results[$];

  meter_state_t meter = '0;
  logic [15:0] interval_ms = blm_pkg::INTERVAL_RST;
  logic [15:0] octet_us    = blm_pkg::OCTET_RST;
  logic [15:0] gap_us      = blm_pkg::FRAME_GAP_RST;
  logic [15:0] ack_us      = blm_pkg::ACK_SLOT_RST;

  int  failures = 0;
  bit  calm = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  function automatic load_result_t meter_step(bus_word_t w);
    logic [31:0] elapsed;
    logic [31:0] octets;
    logic [31:0] frames;
    logic [31:0] busy;
    logic [31:0] div10;
    logic [31:0] pct;
    load_result_t r;
    r.updated = 1'b0;
    if (w.clear) begin
      meter = '0;
    end else begin
      meter.byte_total  = meter.byte_total + 32'(w.frame_bytes);
      meter.frame_total = meter.frame_total + 32'(w.good_frames) + 32'(w.bad_frames);
      if (w.strobe) begin
        if (!meter.ref_valid) begin
          meter.ref_bytes  = meter.byte_total;
          meter.ref_frames = meter.frame_total;
          meter.ref_time   = w.now_ms;
          meter.ref_valid  = 1'b1;
        end else begin
          elapsed = w.now_ms - meter.ref_time;
          if (elapsed >= 32'(interval_ms)) begin
            octets = meter.byte_total - meter.ref_bytes;
            frames = meter.frame_total - meter.ref_frames;
            busy   = octets * 32'(octet_us) + frames * (32'(gap_us) + 32'(ack_us));
            div10  = elapsed * 32'd10;
            if (elapsed == 32'd0)
              meter.rate = 32'hFFFF_FFFF;
            else
              meter.rate = (octets * 32'd1000 + elapsed / 32'd2) / elapsed;
            if (div10 == 32'd0) begin
              pct = 32'h0000_FFFF;
            end else begin
              pct = busy / div10;
              if (pct > 32'h0000_FFFF) pct = 32'h0000_FFFF;
            end
            meter.percent    = pct[15:0];
            meter.ref_bytes  = meter.byte_total;
            meter.ref_frames = meter.frame_total;
            meter.ref_time   = w.now_ms;
            r.updated        = 1'b1;
          end
        end
      end
    end
    r.rate    = meter.rate;
    r.percent = meter.percent;
    return r;
  endfunction

  // driver
  bus_word_t cur_word;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(meter_step(cur_word));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          in_tdata <= {cur_word.now_ms, cur_word.bad_frames, cur_word.good_frames,
                       cur_word.frame_bytes};
          in_tuser <= {cur_word.clear, cur_word.strobe};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  int stall_left = 0;
  int hold_left = 0;
  int results_seen = 0;
  bit hold_done = 1'b0;
  load_result_t exp_res;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected word: bytes_per_second %0h load_percent %0h updated %0b",
                 out_tdata[31:0], out_tdata[47:32], out_tuser[0]);
          failures++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_tdata[31:0] !== exp_res.rate) begin
            $error("bytes_per_second expected %0h actual %0h", exp_res.rate, out_tdata[31:0]);
            failures++;
          end
          if (out_tdata[47:32] !== exp_res.percent) begin
            $error("load_percent expected %0h actual %0h", exp_res.percent, out_tdata[47:32]);
            failures++;
          end
          if (out_tuser[0] !== exp_res.updated) begin
            $error("updated expected %0b actual %0b", exp_res.updated, out_tuser[0]);
            failures++;
          end
        end
      end
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic push_word(logic [15:0] bytes, logic [7:0] good, logic [7:0] bad,
                           logic strobe, logic [31:0] now, logic clear);
    bus_word_t w;
    w.frame_bytes = bytes;
    w.good_frames = good;
    w.bad_frames  = bad;
    w.strobe      = strobe;
    w.now_ms      = now;
    w.clear       = clear;
    pending_words.push_back(w);
  endtask

  task automatic cfg_write(logic [blm_pkg::ADDR_W-1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      blm_pkg::REG_INTERVAL:  interval_ms = value;
      blm_pkg::REG_OCTET:     octet_us    = value;
      blm_pkg::REG_FRAME_GAP: gap_us      = value;
      blm_pkg::REG_ACK_SLOT:  ack_us      = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] ival, logic [15:0] oct, logic [15:0] gap,
                            logic [15:0] ack);
    cfg_write(blm_pkg::REG_INTERVAL, ival);
    cfg_write(blm_pkg::REG_OCTET, oct);
    cfg_write(blm_pkg::REG_FRAME_GAP, gap);
    cfg_write(blm_pkg::REG_ACK_SLOT, ack);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // mostly a steady clock with samples, plus clears and time jumps
  task automatic random_words(int count, int ival);
    int r;
    logic [15:0] bytes;
    logic [7:0] good;
    logic [7:0] bad;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      bytes = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      good  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      bad   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      if (r < 2) begin
        push_word(16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), $urandom, 1'b1);
      end else if (r < 6) begin
        clock_ms = $urandom;
        push_word(bytes, good, bad, 1'($urandom), clock_ms, 1'b0);
      end else begin
        clock_ms = clock_ms + 32'($urandom_range(0, (ival >> 2) + 2));
        push_word(bytes, good, bad, ($urandom_range(0, 4) < 2), clock_ms, 1'b0);
      end
    end
  endtask

  initial begin
    cfg_we = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers: clear, held values, first sample, early sample,
    // exact interval, divisor wrap, time wrap
    push_word(16'hFFFF, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    push_word(16'hFFFF, 8'hFF, 8'hFF, 1'b0, 32'h0000_0000, 1'b0);
    push_word(16'd100, 8'd1, 8'd0, 1'b1, 32'd1000, 1'b0);
    push_word(16'd200, 8'd2, 8'd1, 1'b1, 32'd1500, 1'b0);
    push_word(16'd300, 8'd3, 8'd0, 1'b1, 32'd2000, 1'b0);
    push_word(16'd0, 8'd0, 8'd0, 1'b0, 32'd2100, 1'b0);
    push_word(16'd5000, 8'd10, 8'd5, 1'b1, 32'h8000_07D0, 1'b0);
    push_word(16'd0, 8'd0, 8'd0, 1'b0, 32'd0, 1'b1);
    push_word(16'd10, 8'd1, 8'd1, 1'b1, 32'hFFFF_FF00, 1'b0);
    push_word(16'd4000, 8'd20, 8'd3, 1'b0, 32'd0, 1'b0);
    push_word(16'd4000, 8'd20, 8'd3, 1'b1, 32'h0000_0400, 1'b0);
    push_word(16'd1, 8'd0, 8'd0, 1'b1, 32'h0000_0401, 1'b0);
    drain();

    // zero interval with all timing registers at full scale
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(16'd0, 8'd0, 8'd0, 1'b0, 32'd0, 1'b1);
    push_word(16'd7, 8'd1, 8'd1, 1'b1, 32'd5, 1'b0);
    push_word(16'd0, 8'd0, 8'd0, 1'b1, 32'd5, 1'b0);
    push_word(16'hFFFF, 8'hFF, 8'hFF, 1'b0, 32'd5, 1'b0);
    push_word(16'hFFFF, 8'hFF, 8'hFF, 1'b1, 32'd6, 1'b0);
    push_word(16'd3, 8'd0, 8'd0, 1'b1, 32'd6, 1'b1);
    push_word(16'd3, 8'd0, 8'd0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    push_word(16'd9, 8'd2, 8'd0, 1'b1, 32'h0000_0009, 1'b0);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(16'd1, 16'd0, 16'd0, 16'd0);
        1: set_config(blm_pkg::INTERVAL_RST, blm_pkg::OCTET_RST, blm_pkg::FRAME_GAP_RST,
                      blm_pkg::ACK_SLOT_RST);
        2: set_config(16'($urandom_range(1, 200)), 16'($urandom), 16'($urandom),
                      16'($urandom));
        3: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: set_config(16'($urandom_range(1, 5000)), 16'($urandom), 16'($urandom),
                      16'($urandom));
        default: set_config(16'($urandom_range(10, 100)), 16'($urandom_range(0, 3000)),
                            16'($urandom_range(0, 9000)), 16'($urandom_range(0, 6000)));
      endcase
      if (p == 5) calm = 1'b1;
      clock_ms = $urandom;
      random_words(300, int'(interval_ms));
      drain();
    end

    repeat (100) @(negedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: bus_load_meter.f
rtl/blm_pkg.sv
rtl/blm_mul.sv
rtl/blm_div.sv
rtl/bus_load_meter.sv
sim/tb.sv
